### hdl/assert_macros.svh
// assertion macros shared by the echo mixer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define AEDM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("aedm assertion failed");

`define AEDM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("aedm assertion failed");

`else

`define AEDM_ASSERT(label, clk, rst, prop)

`define AEDM_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### hdl/aedm_pkg.sv
// types and constants of the echo delay mixer
package aedm_pkg;

   localparam int MAX_DELAY = 16384;
   localparam int ADDR_W    = $clog2(MAX_DELAY);
   localparam int SAMPLE_W  = 16;
   localparam int DELAY_W   = 15;
   localparam int DIV_W     = 16;
   localparam int CNT_W     = ADDR_W + 1;
   localparam int DIV_STEPS = SAMPLE_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [DELAY_W-1:0] DELAY_RESET   = DELAY_W'(8000);
   localparam logic [DIV_W-1:0]   DIVISOR_RESET = DIV_W'(4);

   localparam logic CSR_ECHO_DELAY     = 1'b0;
   localparam logic CSR_VOLUME_DIVISOR = 1'b1;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } aedm_state_type;

   typedef struct packed {
      logic load;
      logic ram_read;
      logic div_start;
      logic div_step;
      logic finish;
   } aedm_cmd_type;

   typedef struct packed {
      logic skip_item;
      logic out_free;
   } aedm_status_type;

endpackage

### hdl/aedm_ram.sv
// generic single-clock ram with registered read
module aedm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

### hdl/aedm_ctrl.sv
// controller state machine of the echo delay mixer
`include "assert_macros.svh"

module aedm_ctrl
   import aedm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  aedm_status_type status,
   output aedm_cmd_type    cmd
);

   aedm_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              div_last;

   assign div_last = (step_ff == STEP_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!status.skip_item) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.ram_read = 1'b1;
            state_in     = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_start = 1'b1;
            step_in       = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_last) begin
               step_in  = '0;
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `AEDM_ASSERT(a_step_idle, clock, reset, (state_ff != ST_DIV) |-> (step_ff == '0))
   `AEDM_ASSERT(a_finish_free, clock, reset, cmd.finish |-> status.out_free)
   `AEDM_ASSERT(a_div_len, clock, reset, (cmd.div_step && div_last) |=> (state_ff == ST_FINISH))

endmodule

### hdl/aedm_datapath.sv
// delay line, serial divider, mixer and output word register
`include "assert_macros.svh"

module aedm_datapath
   import aedm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [DIV_W-1:0]           csr_write_data,
   input  logic                       req_operation,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_stream_done,
   input  aedm_cmd_type               cmd,
   output aedm_status_type            status
);

   logic [DELAY_W-1:0]         echo_delay_ff;
   logic [DIV_W-1:0]           volume_divisor_ff;
   logic [ADDR_W-1:0]          wr_pos_ff;
   logic [CNT_W-1:0]           fill_ff;
   logic [CNT_W-1:0]           drain_cnt_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       rsp_done_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       drain_ff;
   logic [SAMPLE_W-1:0]        quot_ff;
   logic [DIV_W-1:0]           rem_ff;
   logic [DIV_W-1:0]           divisor_ff;
   logic                       neg_ff;

   logic [DELAY_W-1:0]  delay_eff;
   logic [DIV_W-1:0]    divisor_eff;
   logic [ADDR_W-1:0]   rd_addr;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic [SAMPLE_W-1:0] echo_raw;
   logic [SAMPLE_W-1:0] echo_mag;
   logic [DIV_W:0]      rem_shift;
   logic                rem_ge;
   logic [SAMPLE_W-1:0] echo_val;
   logic [CNT_W-1:0]    drain_next;
   logic                last_tail;
   logic                drain_now;

   // effective delay and divisor
   always_comb begin
      delay_eff = echo_delay_ff;
      if (echo_delay_ff == '0) begin
         delay_eff = DELAY_W'(1);
      end else if (echo_delay_ff > DELAY_W'(MAX_DELAY)) begin
         delay_eff = DELAY_W'(MAX_DELAY);
      end
   end

   assign divisor_eff = (volume_divisor_ff == '0) ? DIV_W'(1) : volume_divisor_ff;
   assign rd_addr     = wr_pos_ff - delay_eff[ADDR_W-1:0];

   assign drain_now        = (req_operation == OP_DRAIN) || (drain_cnt_ff != '0);
   assign status.skip_item = drain_now && (fill_ff == '0) && (drain_cnt_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   aedm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_DELAY)
   ) u_delay_line (
      .clock         (clock),
      .write_enable  (cmd.finish),
      .write_address (wr_pos_ff),
      .write_data    (x_ff),
      .read_enable   (cmd.ram_read),
      .read_address  (rd_addr),
      .read_data     (ram_rdata)
   );

   // divider operands
   assign echo_raw  = (fill_ff >= delay_eff) ? ram_rdata : '0;
   assign echo_mag  = echo_raw[SAMPLE_W-1] ? (~echo_raw + SAMPLE_W'(1)) : echo_raw;
   assign rem_shift = {rem_ff, quot_ff[SAMPLE_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, divisor_ff};
   assign echo_val  = neg_ff ? (~quot_ff + SAMPLE_W'(1)) : quot_ff;

   assign drain_next = drain_cnt_ff + CNT_W'(1);
   assign last_tail  = drain_ff && (drain_next >= CNT_W'(delay_eff));

   // configuration registers and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         echo_delay_ff     <= DELAY_RESET;
         volume_divisor_ff <= DIVISOR_RESET;
         wr_pos_ff         <= '0;
         fill_ff           <= '0;
         drain_cnt_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_ECHO_DELAY:     echo_delay_ff     <= csr_write_data[DELAY_W-1:0];
               CSR_VOLUME_DIVISOR: volume_divisor_ff <= csr_write_data;
            endcase
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            if (last_tail) begin
               wr_pos_ff    <= '0;
               fill_ff      <= '0;
               drain_cnt_ff <= '0;
            end else begin
               wr_pos_ff <= wr_pos_ff + ADDR_W'(1);
               if (fill_ff < CNT_W'(MAX_DELAY)) begin
                  fill_ff <= fill_ff + CNT_W'(1);
               end
               if (drain_ff) begin
                  drain_cnt_ff <= drain_next;
               end
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         drain_ff <= drain_now;
         x_ff     <= drain_now ? '0 : req_sample_in;
      end
      if (cmd.div_start) begin
         quot_ff    <= echo_mag;
         rem_ff     <= '0;
         neg_ff     <= echo_raw[SAMPLE_W-1];
         divisor_ff <= divisor_eff;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[SAMPLE_W-2:0], rem_ge};
         rem_ff  <= rem_ge ? DIV_W'(rem_shift - {1'b0, divisor_ff}) : rem_shift[DIV_W-1:0];
      end
      if (cmd.finish) begin
         rsp_sample_ff <= x_ff + $signed(echo_val);
         rsp_done_ff   <= last_tail;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_stream_done = rsp_done_ff;

   `AEDM_ASSERT(a_fill_max, clock, reset, fill_ff <= CNT_W'(MAX_DELAY))
   `AEDM_ASSERT(a_drain_fill, clock, reset, (drain_cnt_ff != '0) |-> (fill_ff != '0))
   `AEDM_ASSERT(a_finish_word, clock, reset, cmd.finish |=> rsp_valid_ff)

endmodule

### hdl/audio_echo_delay_mixer_top.sv
// states read, load, div, finish lead to a result word once the output is free
// a new word waits until the ram read and the 16-step serial divider are done
// a word that gives no result (drain with no stream) leaves the block idle
// the next word is taken while a finished result still waits in the output register
// synchronous active-high reset clears control state and loads the register defaults
module audio_echo_delay_mixer_top
   import aedm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [DIV_W-1:0]           csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_operation,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_stream_done
);

   aedm_cmd_type    cmd;
   aedm_status_type status;

   aedm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   aedm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_operation    (req_operation),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_stream_done  (rsp_stream_done),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

### test/audio_echo_delay_mixer_top_test.sv
// self-checking testbench for the audio echo delay mixer top level
`timescale 1ns / 100ps

module audio_echo_delay_mixer_top_test
   import aedm_pkg::*;
();

   localparam int STALL_LIMIT   = 20000;
   localparam int END_WAIT      = 4000;
   localparam int RANDOM_WORDS  = 1500;
   localparam int PRESSURE_HOLD = 400;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       done;
   } mix_word_type;

   class echo_mix_scoreboard;
      logic [DELAY_W-1:0]         delay_reg;
      logic [DIV_W-1:0]           div_reg;
      logic signed [SAMPLE_W-1:0] sample_history [MAX_DELAY];
      int                         wr_pos;
      int                         fill_cnt;
      int                         drain_cnt;
      mix_word_type               mix_queue [$];
      int                         errors;
      int                         words_noted;
      int                         results_checked;
      int                         streams_closed;

      function new();
         delay_reg       = DELAY_RESET;
         div_reg         = DIVISOR_RESET;
         wr_pos          = 0;
         fill_cnt        = 0;
         drain_cnt       = 0;
         errors          = 0;
         words_noted     = 0;
         results_checked = 0;
         streams_closed  = 0;
      endfunction

      function void write_reg(logic idx, logic [DIV_W-1:0] data);
         if (idx == CSR_ECHO_DELAY) begin
            delay_reg = data[DELAY_W-1:0];
         end else begin
            div_reg = data;
         end
      endfunction

      function int effective_delay();
         int d;
         d = delay_reg;
         if (d == 0) d = 1;
         if (d > MAX_DELAY) d = MAX_DELAY;
         return d;
      endfunction

      function bit busy();
         return (fill_cnt != 0) || (drain_cnt != 0);
      endfunction

      function int pending();
         return mix_queue.size();
      endfunction

      // returns 1 when the word gives a result word
      function bit note_word(logic op, logic signed [SAMPLE_W-1:0] value);
         int                  d;
         int                  dv;
         int                  x;
         int                  echo;
         int                  rd;
         bit                  draining;
         logic [SAMPLE_W-1:0] sum;
         mix_word_type        want;
         d = effective_delay();
         dv = (div_reg == 0) ? 1 : int'(div_reg);
         words_noted++;
         draining = (op == OP_DRAIN) || (drain_cnt != 0);
         if (draining && fill_cnt == 0 && drain_cnt == 0) return 1'b0;
         x = draining ? 0 : int'(value);
         echo = 0;
         if (fill_cnt >= d) begin
            rd = (wr_pos >= d) ? wr_pos - d : wr_pos + MAX_DELAY - d;
            echo = int'(sample_history[rd]) / dv;
         end
         sample_history[wr_pos] = SAMPLE_W'(x);
         wr_pos = (wr_pos + 1) % MAX_DELAY;
         if (fill_cnt < MAX_DELAY) fill_cnt++;
         sum = SAMPLE_W'(x + echo);
         want.sample = sum;
         want.done = 1'b0;
         if (draining) begin
            drain_cnt++;
            if (drain_cnt >= d) begin
               want.done = 1'b1;
               fill_cnt  = 0;
               drain_cnt = 0;
               wr_pos    = 0;
            end
         end
         mix_queue.push_back(want);
         return 1'b1;
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_word(logic signed [SAMPLE_W-1:0] got_sample, logic got_done);
         mix_word_type want;
         if (mix_queue.size() == 0) begin
            report($sformatf("result word %0d with nothing expected", got_sample));
            return;
         end
         want = mix_queue.pop_front();
         results_checked++;
         if (got_sample !== want.sample) begin
            report($sformatf("word %0d sample_out %0d, expected %0d",
                             results_checked, got_sample, want.sample));
         end
         if (got_done !== want.done) begin
            report($sformatf("word %0d stream_done %b, expected %b",
                             results_checked, got_done, want.done));
         end
         if (want.done) streams_closed++;
      endtask
   endclass

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic                       csr_index        = CSR_ECHO_DELAY;
   logic [DIV_W-1:0]           csr_write_data   = '0;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic                       req_operation    = OP_SAMPLE;
   logic signed [SAMPLE_W-1:0] req_sample_in    = '0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_stream_done;

   bit                 idling_on    = 1'b1;
   int                 hold_request = 0;
   int                 result_words = 0;
   echo_mix_scoreboard sb           = new();

   audio_echo_delay_mixer_top u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_stream_done  (rsp_stream_done)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 4);
      if (r < 97) return $urandom_range(5, 30);
      return $urandom_range(40, 150);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return SAMPLE_W'($urandom_range(0, 8) - 4);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_word(logic op, logic signed [SAMPLE_W-1:0] value);
      int gap;
      gap = (idling_on && $urandom_range(0, 1) == 1) ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_sample_in <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (sb.note_word(op, value)) result_words++;
   endtask

   // block idle: nothing left in flight on either side
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [DIV_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // result side: random stalls plus the long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            sb.check_word(rsp_sample_out, rsp_stream_done);
         end
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && idling_on && !reset &&
                      $urandom_range(0, 7) == 0) begin
            stall_left = gap_length();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("audio_echo_delay_mixer_top_test: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int               i;
      int               n;
      int               eff;
      int               streams;
      int               start_words;
      logic [DIV_W-1:0] dval;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset defaults, shrinking the delay mid-stream, zero delay and zero divisor
      send_word(OP_DRAIN, 16'sh1234);
      send_word(OP_SAMPLE, 16'sh7FFF);
      send_word(OP_SAMPLE, 16'sh8000);
      send_word(OP_SAMPLE, 16'shFFFF);
      settle();
      write_csr(CSR_ECHO_DELAY, 16'd2);
      write_csr(CSR_VOLUME_DIVISOR, 16'd0);
      send_word(OP_SAMPLE, 16'sh0001);
      send_word(OP_SAMPLE, 16'sh7FFF);
      send_word(OP_SAMPLE, 16'sh7FFF);
      send_word(OP_DRAIN, 16'sh0000);
      send_word(OP_SAMPLE, 16'sh8000);
      send_word(OP_DRAIN, 16'shFFFF);
      settle();
      write_csr(CSR_VOLUME_DIVISOR, 16'hFFFF);
      write_csr(CSR_ECHO_DELAY, 16'd0);
      send_word(OP_SAMPLE, 16'sh8000);
      send_word(OP_SAMPLE, 16'sh7FFF);
      send_word(OP_SAMPLE, 16'sh8000);
      send_word(OP_DRAIN, 16'sh5555);
      settle();
      write_csr(CSR_VOLUME_DIVISOR, 16'd3);
      write_csr(CSR_ECHO_DELAY, 16'h8003);
      send_word(OP_SAMPLE, -16'sd7);
      send_word(OP_SAMPLE, 16'sd5);
      send_word(OP_SAMPLE, 16'sh8000);
      send_word(OP_SAMPLE, 16'sh7FFF);
      send_word(OP_SAMPLE, 16'shFFFF);
      send_word(OP_DRAIN, 16'shAAAA);
      send_word(OP_DRAIN, 16'sh0F0F);
      send_word(OP_DRAIN, 16'shF0F0);
      settle();

      // largest delay: clamped delay, echo not yet reached, then a short drain
      idling_on = 1'b0;
      write_csr(CSR_ECHO_DELAY, DIV_W'(MAX_DELAY));
      write_csr(CSR_VOLUME_DIVISOR, 16'd2);
      for (i = 0; i < 100; i++) send_word(OP_SAMPLE, random_sample());
      settle();
      write_csr(CSR_ECHO_DELAY, 16'h7FFF);
      for (i = 0; i < 50; i++) send_word(OP_SAMPLE, random_sample());
      settle();
      write_csr(CSR_ECHO_DELAY, 16'd4);
      while (sb.busy()) send_word(OP_DRAIN, SAMPLE_W'($urandom));
      settle();

      // random streams
      streams = 0;
      start_words = result_words;
      while (result_words - start_words < RANDOM_WORDS) begin
         settle();
         case ($urandom_range(0, 19))
            0, 1:       dval = 16'd0;
            2:          dval = 16'h8000 | DIV_W'($urandom_range(1, 12));
            3, 4, 5, 6: dval = DIV_W'($urandom_range(17, 200));
            default:    dval = DIV_W'($urandom_range(1, 16));
         endcase
         write_csr(CSR_ECHO_DELAY, dval);
         if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 9))
               0:       dval = 16'd0;
               1:       dval = 16'd1;
               2:       dval = 16'hFFFF;
               3, 4, 5: dval = DIV_W'($urandom_range(2, 8));
               default: dval = DIV_W'($urandom);
            endcase
            write_csr(CSR_VOLUME_DIVISOR, dval);
         end
         eff = sb.effective_delay();
         idling_on = ($urandom_range(0, 5) != 0);
         if (streams == 0) begin
            idling_on    = 1'b1;
            hold_request = PRESSURE_HOLD;
         end
         if ($urandom_range(0, 4) == 0) send_word(OP_DRAIN, SAMPLE_W'($urandom));
         n = $urandom_range(1, 3 * eff + 4);
         if (streams == 0 && n < 40) n = 40;
         for (i = 0; i < n; i++) begin
            if (i == n / 2 && $urandom_range(0, 7) == 0) begin
               settle();
               write_csr(CSR_ECHO_DELAY, DIV_W'($urandom_range(1, 2 * eff)));
               eff = sb.effective_delay();
            end
            send_word(OP_SAMPLE, random_sample());
         end
         send_word(OP_DRAIN, SAMPLE_W'($urandom));
         while (sb.busy()) begin
            if ($urandom_range(0, 63) == 0) begin
               settle();
               write_csr(CSR_ECHO_DELAY, DIV_W'($urandom_range(1, eff)));
            end
            send_word(($urandom_range(0, 3) == 0) ? OP_SAMPLE : OP_DRAIN,
                      SAMPLE_W'($urandom));
         end
         if ($urandom_range(0, 2) == 0) begin
            send_word(OP_DRAIN, SAMPLE_W'($urandom));
            send_word(OP_SAMPLE, random_sample());
            send_word(OP_DRAIN, SAMPLE_W'($urandom));
         end
         streams++;
      end

      req_valid <= 1'b0;
      for (i = 0; i < END_WAIT && sb.pending() != 0; i++) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d expected result words never arrived", sb.pending()));
      end

      $display("run covered %0d input words, %0d result words checked, %0d streams closed",
               sb.words_noted, sb.results_checked, sb.streams_closed);
      $display("%0d random streams after the directed and largest-delay phases, %0d mismatches",
               streams, sb.errors);
      if (sb.errors == 0) begin
         $display("audio_echo_delay_mixer_top_test: done, clean");
      end else begin
         $display("audio_echo_delay_mixer_top_test: done, errors");
      end
      $finish;
   end

endmodule
